// ===== src/atr_pkg.sv =====
// shared constants, widths and tables for the accelerometer tilt block
package atr_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 25;

   localparam int AXIS_W  = 16;
   localparam int RECIP_W = 24;
   localparam int XS_W    = AXIS_W + RECIP_W + 1;
   localparam int XSN_W   = 26;
   localparam int SQ_W    = 49;
   localparam int ROOT_W  = SQRT_STEPS;
   localparam int REMR_W  = ROOT_W + 1;
   localparam int VEC_W   = 34;
   localparam int ANG_W   = 27;
   localparam int DEG_W   = 23;
   localparam int PROD_W  = ANG_W + DEG_W;
   localparam int SAT_W   = 18;

   localparam int PRAD_W = 15;
   localparam int RRAD_W = 16;
   localparam int PDEG_W = 15;
   localparam int RDEG_W = 16;

   localparam logic [RECIP_W-1:0]      RECIP_RESET = RECIP_W'(1024);
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 27'sd26353589;
   localparam logic signed [DEG_W-1:0] DEG_PER_RAD = 23'sd3754936;

   localparam logic signed [SAT_W-1:0] PITCH_RAD_LIM = 18'sd12868;
   localparam logic signed [SAT_W-1:0] ROLL_RAD_LIM  = 18'sd25736;
   localparam logic signed [SAT_W-1:0] PITCH_DEG_LIM = 18'sd11520;
   localparam logic signed [SAT_W-1:0] ROLL_DEG_LIM  = 18'sd23040;

   // atan(2^-i) in q.24 radians
   localparam logic [23:0] ATAN_TAB [24] = '{
      24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
      24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192,
      24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
      24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
   };

   // pipeline stage numbering
   localparam int ST_MUL   = 0;
   localparam int ST_SQ    = 1;
   localparam int ST_REM   = 2;
   localparam int ST_SQRT0 = 3;
   localparam int ST_ROT   = ST_SQRT0 + SQRT_STEPS;
   localparam int ST_CORD0 = ST_ROT + 1;
   localparam int ST_POSTA = ST_CORD0 + CORDIC_STEPS;
   localparam int ST_POSTB = ST_POSTA + 1;
   localparam int NUM_ST   = ST_POSTB + 1;

endpackage

// ===== src/atr_if.sv =====
// request, response and register-write channels of the tilt block
interface atr_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [atr_pkg::AXIS_W-1:0]   accel_x;
   logic signed [atr_pkg::AXIS_W-1:0]   accel_y;
   logic signed [atr_pkg::AXIS_W-1:0]   accel_z;
   modport source (output valid, accel_x, accel_y, accel_z, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [atr_pkg::PRAD_W-1:0]   pitch_radians;
   logic signed [atr_pkg::RRAD_W-1:0]   roll_radians;
   logic signed [atr_pkg::PDEG_W-1:0]   pitch_degrees;
   logic signed [atr_pkg::RDEG_W-1:0]   roll_degrees;
   logic                                pitch_clipped;
   modport source (output valid, pitch_radians, roll_radians, pitch_degrees,
                   roll_degrees, pitch_clipped, input ready);
   modport sink (input valid, pitch_radians, roll_radians, pitch_degrees,
                 roll_degrees, pitch_clipped, output ready);
endinterface

interface atr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [atr_pkg::RECIP_W-1:0]         g_scale_recip;
   modport source (output valid, g_scale_recip, input ready);
   modport sink (input valid, g_scale_recip, output ready);
endinterface

// ===== src/accel_tilt_roll_pitch.sv =====
// tilt top level: pitch as asin of x, roll as atan2 of y over z
//
//   channel   dir   handshake       payload
//   req_bus   in    valid / ready   accel_x, accel_y, accel_z
//   rsp_bus   out   valid / ready   pitch/roll in radians and degrees, pitch_clipped
//   csr_bus   in    valid / ready   g_scale_recip (always ready)
//
// one request per cycle unless every stage is full and the response is stalled;
// each result passes 3 scale/square stages, 25 square-root stages, 1 pre-rotation
// stage, 16 cordic stages and 2 conversion stages. reset clears all valid bits and
// loads g_scale_recip with 1024. a stage holds only while it is full and
// everything after it is full, so bubbles close up under a stalled response
module accel_tilt_roll_pitch (
   input logic     clock,
   input logic     reset,
   atr_req_if.sink   req_bus,
   atr_rsp_if.source rsp_bus,
   atr_csr_if.sink   csr_bus
);
   import atr_pkg::*;

   typedef struct packed {
      logic signed [AXIS_W-1:0] ay;
      logic signed [AXIS_W-1:0] az;
      logic signed [XSN_W-1:0]  xs;
      logic                     rzero;
      logic                     clip;
      logic                     xneg;
   } side_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] ang;
   } rot_type;

   function automatic rot_type pre_rotate(input logic signed [VEC_W-1:0] x,
                                          input logic signed [VEC_W-1:0] y);
      rot_type r;
      r.x   = x;
      r.y   = y;
      r.ang = '0;
      if (x < 0) begin
         if (y >= 0) begin
            r.x   = y;
            r.y   = -x;
            r.ang = ANG_HALF_PI;
         end else begin
            r.x   = -y;
            r.y   = x;
            r.ang = -ANG_HALF_PI;
         end
      end
      return r;
   endfunction

   function automatic logic signed [SAT_W-1:0] sat(input logic signed [SAT_W-1:0] v,
                                                   input logic signed [SAT_W-1:0] lim);
      logic signed [SAT_W-1:0] r;
      r = v;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   localparam logic [SQ_W-1:0]           ONE_SQ   = SQ_W'(1) << (SQ_W - 1);
   localparam logic signed [XS_W-1:0]    ONE_G    = XS_W'(1) << 24;
   localparam logic signed [ANG_W:0]     RAD_HALF = (ANG_W+1)'(1024);
   localparam logic signed [PROD_W:0]    DEG_HALF = (PROD_W+1)'(1) << 32;

   // configuration
   logic [RECIP_W-1:0] recip_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff <= RECIP_RESET;
      end else if (csr_bus.valid) begin
         recip_ff <= csr_bus.g_scale_recip;
      end
   end

   // stage valids and enables
   logic [NUM_ST-1:0] v_ff;
   logic [NUM_ST-1:0] v_in;
   logic [NUM_ST-1:0] en;
   logic [NUM_ST-1:0] holes;

   assign holes = ~v_ff;

   always_comb begin
      for (int i = 0; i < NUM_ST; i++) begin
         en[i] = rsp_bus.ready || ((holes >> i) != '0);
      end
   end

   assign v_in          = {v_ff[NUM_ST-2:0], req_bus.valid};
   assign req_bus.ready = en[ST_MUL];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (en & v_in) | (~en & v_ff);
      end
   end

   // sideband that rides along the pipe
   side_type side_ff [ST_POSTA];
   side_type side_in [ST_POSTA];

   logic signed [XS_W-1:0]    xs_prod;
   logic signed [XS_W-1:0]    xs_ff;
   logic signed [XSN_W-1:0]   xs_n;
   logic signed [2*XSN_W-1:0] sq_full;
   logic [SQ_W-1:0]           sq_ff;
   logic [SQ_W-1:0]           rem_ff;

   assign xs_prod = req_bus.accel_x * $signed({1'b0, recip_ff});
   assign xs_n    = xs_ff[XSN_W-1:0];
   assign sq_full = xs_n * xs_n;

   always_comb begin
      side_in[ST_MUL].ay    = req_bus.accel_y;
      side_in[ST_MUL].az    = req_bus.accel_z;
      side_in[ST_MUL].xs    = '0;
      side_in[ST_MUL].rzero = (recip_ff == '0) ||
                              (req_bus.accel_y == '0 && req_bus.accel_z == '0);
      side_in[ST_MUL].clip  = 1'b0;
      side_in[ST_MUL].xneg  = 1'b0;
      for (int i = 1; i < ST_POSTA; i++) begin
         side_in[i] = side_ff[i-1];
      end
      side_in[ST_SQ].xs   = xs_n;
      side_in[ST_SQ].clip = (xs_ff > ONE_G) || (xs_ff < -ONE_G);
      side_in[ST_SQ].xneg = xs_ff[XS_W-1];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ST_POSTA; i++) begin
         if (en[i]) begin
            side_ff[i] <= side_in[i];
         end
      end
      if (en[ST_MUL]) begin
         xs_ff <= xs_prod;
      end
      // squared value is meaningless when clipped; pitch is forced later
      if (en[ST_SQ]) begin
         sq_ff <= sq_full[SQ_W-1:0];
      end
      if (en[ST_REM]) begin
         rem_ff <= ONE_SQ - sq_ff;
      end
   end

   // sqrt(1 - x*x)
   logic [ROOT_W-1:0] root;

   atr_isqrt u_isqrt (
      .clock    (clock),
      .stage_en (en[ST_SQRT0 +: SQRT_STEPS]),
      .radicand (rem_ff),
      .root     (root)
   );

   // cordic inputs with quadrant pre-rotation
   side_type side_rot;
   rot_type  prot_in;
   rot_type  rrot_in;
   rot_type  prot_ff;
   rot_type  rrot_ff;

   assign side_rot = side_ff[ST_ROT-1];
   assign prot_in  = pre_rotate($signed(VEC_W'(root)) <<< 6, VEC_W'(side_rot.xs) <<< 6);
   assign rrot_in  = pre_rotate(VEC_W'(side_rot.az) <<< 14, VEC_W'(side_rot.ay) <<< 14);

   always_ff @(posedge clock) begin
      if (en[ST_ROT]) begin
         prot_ff <= prot_in;
         rrot_ff <= rrot_in;
      end
   end

   logic signed [ANG_W-1:0] pang_c;
   logic signed [ANG_W-1:0] rang_c;

   atr_cordic u_cordic_pitch (
      .clock    (clock),
      .stage_en (en[ST_CORD0 +: CORDIC_STEPS]),
      .x_in     (prot_ff.x),
      .y_in     (prot_ff.y),
      .ang_in   (prot_ff.ang),
      .ang_out  (pang_c)
   );

   atr_cordic u_cordic_roll (
      .clock    (clock),
      .stage_en (en[ST_CORD0 +: CORDIC_STEPS]),
      .x_in     (rrot_ff.x),
      .y_in     (rrot_ff.y),
      .ang_in   (rrot_ff.ang),
      .ang_out  (rang_c)
   );

   // special cases, then degree scaling product
   side_type                side_post;
   logic signed [ANG_W-1:0] pang_sel;
   logic signed [ANG_W-1:0] rang_sel;
   logic signed [PROD_W-1:0] pprod;
   logic signed [PROD_W-1:0] rprod;
   logic signed [ANG_W-1:0] pang_ff;
   logic signed [ANG_W-1:0] rang_ff;
   logic signed [PROD_W-1:0] pprod_ff;
   logic signed [PROD_W-1:0] rprod_ff;
   logic                    clip_ff;

   assign side_post = side_ff[ST_POSTA-1];
   assign pang_sel  = side_post.clip ? (side_post.xneg ? -ANG_HALF_PI : ANG_HALF_PI)
                                     : pang_c;
   assign rang_sel  = side_post.rzero ? '0 : rang_c;
   assign pprod     = pang_sel * DEG_PER_RAD;
   assign rprod     = rang_sel * DEG_PER_RAD;

   always_ff @(posedge clock) begin
      if (en[ST_POSTA]) begin
         pang_ff  <= pang_sel;
         rang_ff  <= rang_sel;
         pprod_ff <= pprod;
         rprod_ff <= rprod;
         clip_ff  <= side_post.clip;
      end
   end

   // rounding shifts and saturation into the output register
   logic signed [ANG_W:0]  prad_r;
   logic signed [ANG_W:0]  rrad_r;
   logic signed [PROD_W:0] pdeg_r;
   logic signed [PROD_W:0] rdeg_r;
   logic signed [SAT_W-1:0] prad_s;
   logic signed [SAT_W-1:0] rrad_s;
   logic signed [SAT_W-1:0] pdeg_s;
   logic signed [SAT_W-1:0] rdeg_s;

   assign prad_r = (ANG_W+1)'(pang_ff) + RAD_HALF;
   assign rrad_r = (ANG_W+1)'(rang_ff) + RAD_HALF;
   assign pdeg_r = (PROD_W+1)'(pprod_ff) + DEG_HALF;
   assign rdeg_r = (PROD_W+1)'(rprod_ff) + DEG_HALF;
   assign prad_s = sat(SAT_W'(prad_r >>> 11), PITCH_RAD_LIM);
   assign rrad_s = sat(SAT_W'(rrad_r >>> 11), ROLL_RAD_LIM);
   assign pdeg_s = sat(SAT_W'(pdeg_r >>> 33), PITCH_DEG_LIM);
   assign rdeg_s = sat(SAT_W'(rdeg_r >>> 33), ROLL_DEG_LIM);

   logic signed [PRAD_W-1:0] prad_ff;
   logic signed [RRAD_W-1:0] rrad_ff;
   logic signed [PDEG_W-1:0] pdeg_ff;
   logic signed [RDEG_W-1:0] rdeg_ff;
   logic                     pclip_ff;

   always_ff @(posedge clock) begin
      if (en[ST_POSTB]) begin
         prad_ff  <= prad_s[PRAD_W-1:0];
         rrad_ff  <= rrad_s[RRAD_W-1:0];
         pdeg_ff  <= pdeg_s[PDEG_W-1:0];
         rdeg_ff  <= rdeg_s[RDEG_W-1:0];
         pclip_ff <= clip_ff;
      end
   end

   assign rsp_bus.valid         = v_ff[ST_POSTB];
   assign rsp_bus.pitch_radians = prad_ff;
   assign rsp_bus.roll_radians  = rrad_ff;
   assign rsp_bus.pitch_degrees = pdeg_ff;
   assign rsp_bus.roll_degrees  = rdeg_ff;
   assign rsp_bus.pitch_clipped = pclip_ff;

endmodule

// ===== src/atr_isqrt.sv =====
// pipelined floor square root, one result bit per stage
module atr_isqrt (
   input  logic                          clock,
   input  logic [atr_pkg::SQRT_STEPS-1:0] stage_en,
   input  logic [atr_pkg::SQ_W-1:0]      radicand,
   output logic [atr_pkg::ROOT_W-1:0]    root
);
   import atr_pkg::*;

   localparam int VW = 2 * SQRT_STEPS;

   logic [VW-1:0]     val_ff  [SQRT_STEPS];
   logic [REMR_W-1:0] remr_ff [SQRT_STEPS];
   logic [ROOT_W-1:0] q_ff    [SQRT_STEPS];

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_st
      logic [VW-1:0]     val_prev;
      logic [REMR_W-1:0] remr_prev;
      logic [ROOT_W-1:0] q_prev;
      logic [REMR_W+1:0] trial_r;
      logic [REMR_W+1:0] trial_t;
      logic              fits;

      if (i == 0) begin : g_first
         assign val_prev  = VW'(radicand);
         assign remr_prev = '0;
         assign q_prev    = '0;
      end else begin : g_next
         assign val_prev  = val_ff[i-1];
         assign remr_prev = remr_ff[i-1];
         assign q_prev    = q_ff[i-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign trial_r = {remr_prev, val_prev[VW-1 -: 2]};
      assign trial_t = (REMR_W+2)'({q_prev, 2'b01});
      assign fits    = trial_r >= trial_t;

      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            val_ff[i]  <= val_prev << 2;
            remr_ff[i] <= fits ? REMR_W'(trial_r - trial_t) : REMR_W'(trial_r);
            q_ff[i]    <= {q_prev[ROOT_W-2:0], fits};
         end
      end
   end

   assign root = q_ff[SQRT_STEPS-1];

endmodule

// ===== src/atr_cordic.sv =====
// vectoring cordic arctangent, one micro-rotation per stage
module atr_cordic (
   input  logic                                  clock,
   input  logic [atr_pkg::CORDIC_STEPS-1:0]      stage_en,
   input  logic signed [atr_pkg::VEC_W-1:0]      x_in,
   input  logic signed [atr_pkg::VEC_W-1:0]      y_in,
   input  logic signed [atr_pkg::ANG_W-1:0]      ang_in,
   output logic signed [atr_pkg::ANG_W-1:0]      ang_out
);
   import atr_pkg::*;

   logic signed [VEC_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [VEC_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0] a_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
      logic signed [VEC_W-1:0] x_prev;
      logic signed [VEC_W-1:0] y_prev;
      logic signed [ANG_W-1:0] a_prev;
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      logic signed [ANG_W-1:0] step_ang;

      if (i == 0) begin : g_first
         assign x_prev = x_in;
         assign y_prev = y_in;
         assign a_prev = ang_in;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign a_prev = a_ff[i-1];
      end

      assign dx       = y_prev >>> i;
      assign dy       = x_prev >>> i;
      assign step_ang = $signed(ANG_W'(ATAN_TAB[i]));

      // rotate toward the x axis; zero y counts as not above
      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            if (y_prev > 0) begin
               x_ff[i] <= x_prev + dx;
               y_ff[i] <= y_prev - dy;
               a_ff[i] <= a_prev + step_ang;
            end else begin
               x_ff[i] <= x_prev - dx;
               y_ff[i] <= y_prev + dy;
               a_ff[i] <= a_prev - step_ang;
            end
         end
      end
   end

   assign ang_out = a_ff[CORDIC_STEPS-1];

endmodule

// ===== src/atr_checker.sv =====
// port-level checks for the tilt block and their bind
module atr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [atr_pkg::PRAD_W-1:0]  rsp_pitch_radians,
   input logic signed [atr_pkg::RRAD_W-1:0]  rsp_roll_radians,
   input logic signed [atr_pkg::PDEG_W-1:0]  rsp_pitch_degrees,
   input logic                               rsp_pitch_clipped
);
   import atr_pkg::*;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a clipped pitch is exactly a quarter turn
   a_clip_rad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch_clipped |->
         (rsp_pitch_radians == 15'sd12868 || rsp_pitch_radians == -15'sd12868))
      else $error("clipped pitch not at quarter turn (radians)");

   a_clip_deg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch_clipped |->
         (rsp_pitch_degrees == 15'sd11520 || rsp_pitch_degrees == -15'sd11520))
      else $error("clipped pitch not at quarter turn (degrees)");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_radians <= 16'sd25736 && rsp_roll_radians >= -16'sd25736))
      else $error("roll out of range");

endmodule

bind accel_tilt_roll_pitch atr_checker u_atr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_pitch_radians (rsp_bus.pitch_radians),
   .rsp_roll_radians  (rsp_bus.roll_radians),
   .rsp_pitch_degrees (rsp_bus.pitch_degrees),
   .rsp_pitch_clipped (rsp_bus.pitch_clipped)
);
